[rtl/core/rhc_pkg.sv]
// Shared types and constants of the RGB to HSV converter.
// Holds the per-stage work record that travels down the division pipeline.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rhc_pkg;

	localparam int ChanW  = 8;
	localparam int HueW   = 15;
	localparam int HueQw  = 12;   // hue quotient bits, quotient never exceeds one sixth (3840)
	localparam int SatQw  = 8;    // saturation quotient bits
	localparam int HueNumW = ChanW + HueQw;
	localparam int SatNumW = ChanW + SatQw;

	localparam logic [HueW-1:0] HueSixth     = 15'd3840;
	localparam logic [HueW-1:0] HueGreenBase = 15'd7680;
	localparam logic [HueW-1:0] HueBlueBase  = 15'd15360;
	localparam logic signed [15:0] HueTurn   = 16'sd23040;

	// Largest channel; red wins ties over green, green over blue
	typedef enum logic [1:0] {
		SectRed   = 2'b00,
		SectGreen = 2'b01,
		SectBlue  = 2'b10
	} rhc_sect_t;

	typedef struct packed {
		logic [ChanW-1:0] val;       // largest channel
		logic [ChanW-1:0] span;      // max - min, hue divisor
		rhc_sect_t        sect;
		logic             neg;       // hue offset within the sector is negative
		logic [ChanW-1:0] hrem;      // hue partial remainder
		logic [HueQw-1:0] hnq;       // remaining hue numerator bits / quotient bits
		logic [ChanW-1:0] srem;      // saturation partial remainder
		logic [SatQw-1:0] snq;       // remaining saturation numerator bits / quotient bits
	} rhc_work_t;

endpackage

`default_nettype wire

[rtl/core/rhc_front.sv]
// Front end of the RGB to HSV converter: max/min search, sector choice and
// division set-up over two register stages. Depends on rhc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rhc_front import rhc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire logic             in_valid,
	input  wire logic [ChanW-1:0] red,
	input  wire logic [ChanW-1:0] green,
	input  wire logic [ChanW-1:0] blue,
	output logic                  out_valid,
	output rhc_work_t             out_work
);

	logic [ChanW-1:0]   mx, mn;
	rhc_sect_t          sect;
	logic signed [ChanW:0] diff;

	logic               valid_s1;
	logic [ChanW-1:0]   val_s1, span_s1, adiff_s1;
	rhc_sect_t          sect_s1;
	logic               neg_s1;

	logic [HueNumW-1:0] hnum;
	logic [SatNumW-1:0] snum;
	rhc_work_t          work_nx;

	logic               valid_s2;
	rhc_work_t          work_s2;

	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		if (mx == red) begin
			sect = SectRed;
			diff = $signed({1'b0, green}) - $signed({1'b0, blue});
		end else if (mx == green) begin
			sect = SectGreen;
			diff = $signed({1'b0, blue}) - $signed({1'b0, red});
		end else begin
			sect = SectBlue;
			diff = $signed({1'b0, red}) - $signed({1'b0, green});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			val_s1   <= mx;
			span_s1  <= mx - mn;
			sect_s1  <= sect;
			neg_s1   <= diff[ChanW];
			adiff_s1 <= diff[ChanW] ? ChanW'(-diff) : diff[ChanW-1:0];
		end
	end

	// 3840 * |diff| = (|diff| << 12) - (|diff| << 8); span * 255 likewise
	always_comb begin
		hnum = {adiff_s1, 12'b0} - {4'b0, adiff_s1, 8'b0};
		snum = {span_s1, 8'b0} - {8'b0, span_s1};
		work_nx.val  = val_s1;
		work_nx.span = span_s1;
		work_nx.sect = sect_s1;
		work_nx.neg  = neg_s1;
		// upper numerator bits are already below the divisor
		work_nx.hrem = hnum[HueNumW-1:HueQw];
		work_nx.hnq  = hnum[HueQw-1:0];
		work_nx.srem = snum[SatNumW-1:SatQw];
		work_nx.snq  = snum[SatQw-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv) work_s2 <= work_nx;
	end

	assign out_valid = valid_s2;
	assign out_work  = work_s2;

endmodule

`default_nettype wire

[rtl/core/rhc_div_step.sv]
// One registered restoring-division stage: one hue quotient bit and, in the
// first stages, one saturation quotient bit. Depends on rhc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rhc_div_step import rhc_pkg::*; #(
	parameter int StepIdx = 0
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      adv,
	input  wire logic      in_valid,
	input  wire rhc_work_t in_work,
	output logic           out_valid,
	output rhc_work_t      out_work
);

	localparam logic SatActive = (StepIdx < SatQw);

	logic [ChanW:0] htry, stry;
	rhc_work_t      work_nx;
	logic           valid_sn;
	rhc_work_t      work_sn;

	always_comb begin
		work_nx = in_work;
		htry = {in_work.hrem, in_work.hnq[HueQw-1]};
		if (htry >= {1'b0, in_work.span}) begin
			work_nx.hrem = ChanW'(htry - {1'b0, in_work.span});
			work_nx.hnq  = {in_work.hnq[HueQw-2:0], 1'b1};
		end else begin
			work_nx.hrem = htry[ChanW-1:0];
			work_nx.hnq  = {in_work.hnq[HueQw-2:0], 1'b0};
		end
		stry = {in_work.srem, in_work.snq[SatQw-1]};
		if (SatActive) begin
			if (stry >= {1'b0, in_work.val}) begin
				work_nx.srem = ChanW'(stry - {1'b0, in_work.val});
				work_nx.snq  = {in_work.snq[SatQw-2:0], 1'b1};
			end else begin
				work_nx.srem = stry[ChanW-1:0];
				work_nx.snq  = {in_work.snq[SatQw-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_sn <= 1'b0;
		else if (adv) valid_sn <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) work_sn <= work_nx;
	end

	assign out_valid = valid_sn;
	assign out_work  = work_sn;

endmodule

`default_nettype wire

[rtl/core/rhc_back.sv]
// Output stage of the RGB to HSV converter: floor correction, sector offset,
// wrap and the output register. Depends on rhc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rhc_back import rhc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire logic             in_valid,
	input  wire rhc_work_t        in_work,
	output logic                  out_valid,
	output logic [HueW-1:0]       hue,
	output logic [ChanW-1:0]      sat,
	output logic [ChanW-1:0]      val
);

	logic [HueW-1:0]       base;
	logic [HueQw:0]        qmag;
	logic signed [15:0]    qsgn, hsum, hwrap;
	logic [HueW-1:0]       hue_nx;
	logic [ChanW-1:0]      sat_nx;

	logic                  valid_so;
	logic [HueW-1:0]       hue_so;
	logic [ChanW-1:0]      sat_so, val_so;

	always_comb begin
		case (in_work.sect)
			SectGreen: base = HueGreenBase;
			SectBlue:  base = HueBlueBase;
			default:   base = '0;
		endcase
		// floor of a negative quotient: round the magnitude up
		qmag  = {1'b0, in_work.hnq} + (HueQw+1)'(in_work.neg && (in_work.hrem != '0));
		qsgn  = in_work.neg ? -$signed({3'b0, qmag}) : $signed({3'b0, qmag});
		hsum  = $signed({1'b0, base}) + qsgn;
		hwrap = (hsum < 0) ? hsum + HueTurn : hsum;
		hue_nx = (in_work.span == '0) ? '0 : hwrap[HueW-1:0];
		sat_nx = (in_work.val == '0) ? '0 : in_work.snq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_so <= 1'b0;
		else if (adv) valid_so <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hue_so <= hue_nx;
			sat_so <= sat_nx;
			val_so <= in_work.val;
		end
	end

	assign out_valid = valid_so;
	assign hue = hue_so;
	assign sat = sat_so;
	assign val = val_so;

endmodule

`default_nettype wire

[rtl/core/rgb_to_hsv_converter_unit.sv]
// RGB to HSV converter, top level: front end, 12 division stages, output stage.
// Throughput: one pixel per cycle; the whole pipeline holds while the output
// transaction is stalled, so s_tready is high while the output is empty or taken.
// Reset: arst_n clears all valid bits asynchronously; data registers are not reset.
// Depends on rhc_pkg, rhc_front, rhc_div_step, rhc_back.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsv_converter_unit import rhc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata    // hue_out[14:0], sat_out[22:15], val_out[30:23], zero[31]
);

	logic             adv;
	logic [HueQw:0]   vld;
	rhc_work_t        wrk [HueQw+1];
	logic [HueW-1:0]  hue;
	logic [ChanW-1:0] sat, val;

	// advance every stage unless the output register is stalled
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	rhc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (s_tvalid),
		.red      (s_tdata[7:0]),
		.green    (s_tdata[15:8]),
		.blue     (s_tdata[23:16]),
		.out_valid(vld[0]),
		.out_work (wrk[0])
	);

	for (genvar i = 0; i < HueQw; i++) begin : g_div
		rhc_div_step #(.StepIdx(i)) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.in_valid (vld[i]),
			.in_work  (wrk[i]),
			.out_valid(vld[i+1]),
			.out_work (wrk[i+1])
		);
	end

	rhc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (vld[HueQw]),
		.in_work  (wrk[HueQw]),
		.out_valid(m_tvalid),
		.hue      (hue),
		.sat      (sat),
		.val      (val)
	);

	assign m_tdata = {1'b0, val, sat, hue};

endmodule

`default_nettype wire

[rtl/core/rhc_checker.sv]
// Port-level checks for the RGB to HSV converter, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module rhc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata
);

	// hold a stalled output transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output transaction changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow the output stall");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[14:0] < 15'd23040) && !m_tdata[31])
		else $error("hue out of range");

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[30:23] == 8'd0) |-> (m_tdata[22:15] == 8'd0))
		else $error("black pixel with nonzero saturation");

	// zero saturation only for a grey pixel, which has zero hue
	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[22:15] == 8'd0) |-> (m_tdata[14:0] == 15'd0))
		else $error("grey pixel with nonzero hue");

endmodule

bind rgb_to_hsv_converter_unit rhc_checker u_rhc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

[sim/rgb_to_hsv_checker.sv]
// Checker for rgb_to_hsv_converter_unit: watches both stream channels, predicts
// hue, saturation and value for every accepted pixel and compares in order.
// Depends on rhc_pkg for the channel widths and the sector enum.
`timescale 1ns / 1ps

module rgb_to_hsv_checker import rhc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // hue_out[14:0], sat_out[22:15], val_out[30:23], zero[31]
	output int          mismatches,
	output int          pending,
	output int          checked,
	output int          grey_seen,
	output int          wrap_seen
);

	localparam int HueSector = 3840;    // 60 degrees in 1/64 degree units
	localparam int HueCircle = 23040;
	localparam int FullScale = 255;

	typedef struct {
		logic [23:0]      pixel;
		logic [HueW-1:0]  hue;
		logic [ChanW-1:0] sat;
		logic [ChanW-1:0] val;
	} hsv_expect_t;

	hsv_expect_t hsv_expected[$];
	hsv_expect_t want;

	function automatic hsv_expect_t predict_hsv(input logic [23:0] pixel);
		int r;
		int g;
		int b;
		int hi;
		int lo;
		int span;
		int base;
		int delta;
		int num;
		int hue;
		int sat;
		rhc_sect_t sect;
		hsv_expect_t res;
		r = pixel[7:0];
		g = pixel[15:8];
		b = pixel[23:16];
		hi = r;
		lo = r;
		if (g > hi) hi = g;
		if (b > hi) hi = b;
		if (g < lo) lo = g;
		if (b < lo) lo = b;
		span = hi - lo;
		hue = 0;
		if (span != 0) begin
			// red takes ties over green, green over blue
			if (hi == r) sect = SectRed;
			else if (hi == g) sect = SectGreen;
			else sect = SectBlue;
			case (sect)
				SectRed: begin
					base = 0;
					delta = g - b;
				end
				SectGreen: begin
					base = 2;
					delta = b - r;
				end
				default: begin
					base = 4;
					delta = r - g;
				end
			endcase
			num = HueSector * (base * span + delta);
			// floor towards minus infinity, then wrap once into the circle
			if (num >= 0) hue = num / span;
			else hue = -((-num + span - 1) / span);
			if (hue < 0) hue += HueCircle;
		end
		sat = (hi == 0) ? 0 : (span * FullScale) / hi;
		res.pixel = pixel;
		res.hue = hue[HueW-1:0];
		res.sat = sat[ChanW-1:0];
		res.val = hi[ChanW-1:0];
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int exp_val,
			input logic [23:0] pixel);
		$display("MISMATCH %s: got %0d, want %0d (pixel b/g/r %06h) at %0t",
			what, got, exp_val, pixel, $realtime);
		mismatches++;
	endtask

	initial begin
		mismatches = 0;
		checked = 0;
		grey_seen = 0;
		wrap_seen = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsv_expected.delete();
			pending <= 0;
		end else begin
			// retire the output transaction before taking the new pixel
			if (m_tvalid && m_tready) begin
				if (hsv_expected.size() == 0) begin
					report_mismatch("result with no pixel waiting", m_tdata, 0, 24'h0);
				end else begin
					want = hsv_expected.pop_front();
					checked++;
					if (want.sat == 0) grey_seen++;
					if (want.hue >= 19200) wrap_seen++;
					if (m_tdata[14:0] !== want.hue)
						report_mismatch("hue_out", m_tdata[14:0], want.hue, want.pixel);
					if (m_tdata[22:15] !== want.sat)
						report_mismatch("sat_out", m_tdata[22:15], want.sat, want.pixel);
					if (m_tdata[30:23] !== want.val)
						report_mismatch("val_out", m_tdata[30:23], want.val, want.pixel);
					if (m_tdata[31] !== 1'b0)
						report_mismatch("tdata pad bit", m_tdata[31], 0, want.pixel);
				end
			end
			if (s_tvalid && s_tready)
				hsv_expected = {hsv_expected, predict_hsv(s_tdata)};
			pending <= hsv_expected.size();
		end
	end

endmodule

[sim/tb_rgb_to_hsv_converter_unit.sv]
// Testbench top for rgb_to_hsv_converter_unit: clock, reset, pixel stimulus,
// output back-pressure and the verdict. Checking lives in rgb_to_hsv_checker.
// Depends on rhc_pkg, the converter RTL and sim/rgb_to_hsv_checker.sv.
`timescale 1ns / 1ps

module tb_rgb_to_hsv_converter_unit;

	localparam int CycleLimit = 200000;
	localparam int HoldCycles = 300;
	localparam int TailCycles = 20;
	localparam int PhaseItems = 220;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;     // red_in[7:0], green_in[15:8], blue_in[23:16]
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;     // hue_out[14:0], sat_out[22:15], val_out[30:23], zero[31]

	int mismatches;
	int pending;
	int checked;
	int grey_seen;
	int wrap_seen;

	int idle_pct = 0;
	int stall_pct = 0;
	int hold_reqs = 0;
	int pixels_sent = 0;
	int cycle_cnt = 0;

	always #4 clk = ~clk;

	rgb_to_hsv_converter_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	rgb_to_hsv_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.mismatches (mismatches),
		.pending    (pending),
		.checked    (checked),
		.grey_seen  (grey_seen),
		.wrap_seen  (wrap_seen)
	);

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CycleLimit) begin
			$display("timeout after %0d cycles, %0d results still due", cycle_cnt, pending);
			$display("rgb_to_hsv_converter_unit verification failed");
			$finish;
		end
	end

	// Output side: random stalls, plus a long hold-off on request
	initial begin
		int seen;
		seen = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_reqs != seen) begin
				seen = hold_reqs;
				m_tready <= 1'b0;
				for (int n = 0; n < HoldCycles; n++) @(posedge clk);
			end
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {b, g, r};
		// hold until the transaction is taken
		do @(posedge clk); while (!s_tready);
		pixels_sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	function automatic logic [23:0] random_pixel();
		logic [7:0] c0;
		logic [7:0] c1;
		logic [7:0] c2;
		int mode;
		mode = $urandom_range(99);
		c0 = 8'($urandom);
		c1 = 8'($urandom);
		c2 = 8'($urandom);
		if (mode < 60) begin
			return {c2, c1, c0};
		end else if (mode < 75) begin
			// greys and pixels with two equal channels, tying for the largest or the smallest
			case ($urandom_range(3))
				0: return {c0, c0, c0};
				1: return {c1, c0, c0};
				2: return {c0, c1, c0};
				default: return {c0, c0, c1};
			endcase
		end else if (mode < 90) begin
			// channels at the ends of the range
			c0 = $urandom_range(1) ? 8'hff : 8'h00;
			c1 = $urandom_range(2) == 0 ? 8'hff : $urandom_range(1) ? 8'h00 : c1;
			return {c2, c1, c0};
		end else begin
			// nearly grey: small span drives the hue division hardest
			c1 = c0 + 8'($urandom_range(2));
			c2 = c0 - 8'($urandom_range(2));
			case ($urandom_range(2))
				0: return {c2, c1, c0};
				1: return {c1, c0, c2};
				default: return {c0, c2, c1};
			endcase
		end
	endfunction

	task automatic run_phase(input int items, input int sender_idle, input int receiver_stall);
		logic [23:0] px;
		idle_pct = sender_idle;
		stall_pct <= receiver_stall;
		for (int i = 0; i < items; i++) begin
			px = random_pixel();
			send_pixel(px[7:0], px[15:8], px[23:16]);
		end
	endtask

	initial begin
		int directed;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pixels, r/g/b order
		send_pixel(8'd0, 8'd0, 8'd0);        // black
		send_pixel(8'd255, 8'd255, 8'd255);  // white
		send_pixel(8'd128, 8'd128, 8'd128);  // grey
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd1);      // red sector, negative hue wraps
		send_pixel(8'd255, 8'd0, 8'd255);    // red ties blue, wraps to the bottom edge
		send_pixel(8'd255, 8'd255, 8'd0);    // red ties green
		send_pixel(8'd0, 8'd255, 8'd255);    // green ties blue
		send_pixel(8'd1, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd1);
		send_pixel(8'd1, 8'd1, 8'd0);
		send_pixel(8'd255, 8'd254, 8'd0);
		send_pixel(8'd254, 8'd0, 8'd255);    // blue sector near the top
		send_pixel(8'd0, 8'd1, 8'd255);
		send_pixel(8'd0, 8'd255, 8'd254);
		send_pixel(8'd255, 8'd254, 8'd254);  // tiny span at full value
		send_pixel(8'd200, 8'd100, 8'd50);
		send_pixel(8'd128, 8'd64, 8'd255);
		send_pixel(8'd85, 8'd170, 8'd170);
		send_pixel(8'd170, 8'd85, 8'd171);
		directed = pixels_sent;

		run_phase(PhaseItems, 0, 0);
		run_phase(PhaseItems, 76, 0);
		run_phase(PhaseItems, 0, 76);
		run_phase(PhaseItems, 25, 25);

		// long output hold while pixels keep coming, so the input stalls
		wait_drained();
		hold_reqs <= hold_reqs + 1;
		run_phase(60, 0, 0);
		wait_drained();

		repeat (TailCycles) @(posedge clk);
		$display("Sent %0d pixels (%0d directed) over four idle/stall mixes and a %0d-cycle hold;",
			pixels_sent, directed, HoldCycles);
		$display("%0d results checked, %0d grey or black, %0d with wrapped hue.",
			checked, grey_seen, wrap_seen);
		if (mismatches == 0 && pending == 0)
			$display("rgb_to_hsv_converter_unit verification clean");
		else
			$display("rgb_to_hsv_converter_unit verification failed");
		$finish;
	end

endmodule
